// ===== hdl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

   localparam int WORK_RAM_BYTES = 8192;
   localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);

   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 13;
   localparam int MAPPED_W = 21;
   localparam int PIC_BANKS = 8;
   localparam int PRG_BANKS = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ADDR_W-1:0] WRAM_BASE = 16'h6000;
   localparam logic [ADDR_W-1:0] ROM_BASE  = 16'h8000;
   localparam logic [ADDR_W-1:0] REG_LAST  = 16'h800F;
   localparam logic [13:0]       NT_BASE   = 14'h2000;
   localparam logic [13:0]       PAL_BASE  = 14'h3F00;

   localparam logic [BYTE_W-1:0] PRG_BANK_RESET [PRG_BANKS] =
      '{8'hFC, 8'hFD, 8'hFE, 8'hFF};
   localparam logic [BYTE_W-1:0] MASK_RESET = 8'hFF;

   typedef enum logic [1:0] {
      OP_CPU_WRITE = 2'd0,
      OP_CPU_READ  = 2'd1,
      OP_PPU_READ  = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_PRG  = 3'd1,
      TGT_WRAM = 3'd2,
      TGT_CHR  = 3'd3,
      TGT_NT   = 3'd4
   } target_type;

   typedef enum logic [0:0] {
      REG_PRG_MASK = 1'b0,
      REG_CHR_MASK = 1'b1
   } reg_index_type;

   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  address;
      logic [BYTE_W-1:0]  data;
      logic [BYTE_W-1:0]  cycles;
   } req_type;

   typedef struct packed {
      target_type           target;
      logic [MAPPED_W-1:0]  mapped_address;
      logic                 irq;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] prg;
      logic [BYTE_W-1:0] chr;
   } mask_type;

endpackage

// ===== hdl/cbm_req_if.sv =====
// Request channel: bus events into the mapper.
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] address;
   logic [7:0]  data;
   logic [7:0]  cycles;

   modport source (output valid, output op, output address, output data, output cycles,
                   input ready);
   modport sink   (input valid, input op, input address, input data, input cycles,
                   output ready);
endinterface

// ===== hdl/cbm_rsp_if.sv =====
// Response channel: translated accesses and interrupt level.
interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic [20:0] mapped_address;
   logic        irq;

   modport source (output valid, output target, output mapped_address, output irq,
                   input ready);
   modport sink   (input valid, input target, input mapped_address, input irq,
                   output ready);
endinterface

// ===== hdl/cbm_csr.sv =====
// APB register file holding the program and picture bank masks.
module cbm_csr
   import cbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output mask_type              masks
);

   mask_type      masks_ff, masks_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      masks_in = masks_ff;
      prdata   = '0;
      unique case (idx)
         REG_PRG_MASK: begin
            prdata = CSR_DATA_W'(masks_ff.prg);
            if (wr_en) masks_in.prg = pwdata[BYTE_W-1:0];
         end
         REG_CHR_MASK: begin
            prdata = CSR_DATA_W'(masks_ff.chr);
            if (wr_en) masks_in.chr = pwdata[BYTE_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff.prg <= MASK_RESET;
         masks_ff.chr <= MASK_RESET;
      end else begin
         masks_ff <= masks_in;
      end
   end

   assign masks = masks_ff;

endmodule

// ===== hdl/cbm_xlate.sv =====
// Bank registers, cycle counter and address translation for one bus event.
module cbm_xlate
   import cbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  item,
   input  mask_type masks,
   output rsp_type  result
);

   logic [BYTE_W-1:0]   pic_ff [PIC_BANKS];
   logic [BYTE_W-1:0]   pic_in [PIC_BANKS];
   logic [BYTE_W-1:0]   prg_ff [PRG_BANKS];
   logic [BYTE_W-1:0]   prg_in [PRG_BANKS];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                irq_ff, irq_in;
   logic [ADDR_W-1:0]   a;
   logic [13:0]         p;
   logic [BYTE_W-1:0]   prg_bank, chr_bank;
   target_type          tgt;
   logic [MAPPED_W-1:0] maddr;

   assign a        = item.address;
   assign p        = a[13:0];
   assign prg_bank = prg_ff[a[14:13]] & masks.prg;
   assign chr_bank = pic_ff[p[12:10]] & masks.chr;

   always_comb begin
      pic_in = pic_ff;
      prg_in = prg_ff;
      cnt_in = cnt_ff;
      irq_in = irq_ff;
      tgt    = TGT_NONE;
      maddr  = '0;
      unique case (item.op)
         OP_CPU_WRITE, OP_CPU_READ: begin
            if (a >= WRAM_BASE && a < ROM_BASE) begin
               tgt   = TGT_WRAM;
               maddr = MAPPED_W'(a[WRAM_AW-1:0]);
            end else if (a >= ROM_BASE) begin
               if (item.op == OP_CPU_READ) begin
                  tgt   = TGT_PRG;
                  maddr = MAPPED_W'({prg_bank, a[12:0]});
               end else if (a <= REG_LAST) begin
                  // low nibble: 0-7 picture bank, 8-B program bank, D/F irq clear
                  if (!a[3]) begin
                     pic_in[a[2:0]] = item.data;
                  end else if (!a[2]) begin
                     prg_in[a[1:0]] = item.data;
                  end else if (a[0]) begin
                     cnt_in = '0;
                     irq_in = 1'b0;
                  end
               end
            end
         end
         OP_PPU_READ: begin
            if (p < NT_BASE) begin
               tgt   = TGT_CHR;
               maddr = MAPPED_W'({chr_bank, p[9:0]});
            end else if (p < PAL_BASE) begin
               tgt   = TGT_NT;
               maddr = MAPPED_W'(p[10:0]);
            end
         end
         OP_TICK: begin
            cnt_in = cnt_ff + CNT_W'(item.cycles);
            if (cnt_in[CNT_W-1]) irq_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIC_BANKS; i++) pic_ff[i] <= '0;
         for (int i = 0; i < PRG_BANKS; i++) prg_ff[i] <= PRG_BANK_RESET[i];
         cnt_ff <= '0;
         irq_ff <= 1'b0;
      end else if (fire) begin
         pic_ff <= pic_in;
         prg_ff <= prg_in;
         cnt_ff <= cnt_in;
         irq_ff <= irq_in;
      end
   end

   assign result.target         = tgt;
   assign result.mapped_address = maddr;
   assign result.irq            = irq_in;

   a_irq_rise_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> $past(fire && item.op == OP_TICK))
      else $error("irq latched without a tick");

   a_irq_fall_on_write: assert property (@(posedge clock) disable iff (reset)
      $fell(irq_ff) && !$past(reset) |-> $past(fire && item.op == OP_CPU_WRITE))
      else $error("irq dropped without a clearing write");

   a_none_zero_addr: assert property (@(posedge clock) disable iff (reset)
      fire && tgt == TGT_NONE |-> maddr == '0)
      else $error("nonzero address with no target");

   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !fire |=> $stable(cnt_ff))
      else $error("cycle counter moved without a transfer");

endmodule

// ===== hdl/cartridge_bank_mapper_irq.sv =====
// Top level of the cartridge bank mapper with cycle-counting interrupt.
// The mapper takes one bus event per clock (CPU write, CPU read, PPU read or
// cycle tick) unless held by response back-pressure, and returns exactly one
// response per event, in order. An event is captured in an input register,
// translated and applied to the bank registers and cycle counter in a single
// pass, and the response lands in an output register, with one translation
// stage between the two registers. Bank and interrupt updates from one event
// are visible to the very next event. The bank masks are written through the
// APB port at byte addresses 0 (program) and 4 (picture) and should only
// change while no event is in flight.
module cartridge_bank_mapper_irq
   import cbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cbm_req_if.sink               req_bus,
   cbm_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   mask_type masks;
   req_type  in_ff;
   logic     in_vld_ff;
   rsp_type  out_ff, result;
   logic     out_vld_ff;
   logic     advance, take;

   cbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .masks   (masks)
   );

   // advance the captured event whenever the output slot is free or drains
   assign advance       = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff <= '0;
      end else if (take) begin
         in_ff.op      <= op_type'(req_bus.op);
         in_ff.address <= req_bus.address;
         in_ff.data    <= req_bus.data;
         in_ff.cycles  <= req_bus.cycles;
      end
   end

   cbm_xlate u_xlate (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_ff),
      .masks  (masks),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= result;
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.target         = out_ff.target;
   assign rsp_bus.mapped_address = out_ff.mapped_address;
   assign rsp_bus.irq            = out_ff.irq;

   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      take |=> in_vld_ff)
      else $error("accepted transfer not held in input stage");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("translated event did not reach output register");

endmodule

// ===== tb/cartridge_bank_mapper_irq_test.sv =====
// Testbench for the cartridge bank mapper: predicts every translation and checks it.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_test
   import cbm_pkg::*;
();

   localparam int STALL_LIMIT   = 5000;
   localparam int PHASES        = 8;
   localparam int RANDOM_EVENTS = 200;
   localparam int CALM_PHASE    = 4;

   // Bank state, masks and pending translations of the mapper.
   class mapper_model;
      logic [BYTE_W-1:0] prg_mask;
      logic [BYTE_W-1:0] chr_mask;
      logic [BYTE_W-1:0] pic_bank [PIC_BANKS];
      logic [BYTE_W-1:0] prog_bank [PRG_BANKS];
      logic [CNT_W-1:0]  cycle_count;
      logic              irq_latched;
      rsp_type           pending_translations[$];
      int                mismatches;

      function new();
         prg_mask    = MASK_RESET;
         chr_mask    = MASK_RESET;
         cycle_count = '0;
         irq_latched = 1'b0;
         mismatches  = 0;
         foreach (pic_bank[i]) pic_bank[i] = '0;
         foreach (prog_bank[i]) prog_bank[i] = PRG_BANK_RESET[i];
      endfunction

      function void set_mask(reg_index_type idx, logic [BYTE_W-1:0] value);
         if (idx == REG_PRG_MASK) prg_mask = value;
         else chr_mask = value;
      endfunction

      function void note_event(req_type ev);
         rsp_type           want;
         logic [ADDR_W-1:0] a;
         logic [13:0]       p;
         logic [BYTE_W-1:0] bank;
         a    = ev.address;
         p    = a[13:0];
         want = '{TGT_NONE, '0, 1'b0};
         case (ev.op)
            OP_CPU_WRITE, OP_CPU_READ: begin
               if (a >= WRAM_BASE && a < ROM_BASE) begin
                  want.target         = TGT_WRAM;
                  want.mapped_address = MAPPED_W'((a - WRAM_BASE) & (WORK_RAM_BYTES - 1));
               end else if (a >= ROM_BASE) begin
                  if (ev.op == OP_CPU_READ) begin
                     bank                = prog_bank[a[14:13]] & prg_mask;
                     want.target         = TGT_PRG;
                     want.mapped_address = {bank, a[12:0]};
                  end else if (a <= REG_LAST) begin
                     if (!a[3]) pic_bank[a[2:0]] = ev.data;
                     else if (!a[2]) prog_bank[a[1:0]] = ev.data;
                     else if (a[0]) begin
                        // odd addresses in the top quad clear counter and interrupt
                        cycle_count = '0;
                        irq_latched = 1'b0;
                     end
                  end
               end
            end
            OP_PPU_READ: begin
               if (p < NT_BASE) begin
                  bank                = pic_bank[p[12:10]] & chr_mask;
                  want.target         = TGT_CHR;
                  want.mapped_address = {3'b000, bank, p[9:0]};
               end else if (p < PAL_BASE) begin
                  want.target         = TGT_NT;
                  want.mapped_address = {10'b0, p[10:0]};
               end
            end
            default: begin
               cycle_count = cycle_count + CNT_W'(ev.cycles);
               if (cycle_count[CNT_W-1]) irq_latched = 1'b1;
            end
         endcase
         want.irq = irq_latched;
         pending_translations.push_back(want);
      endfunction

      function void check_translation(rsp_type got);
         rsp_type want;
         if (pending_translations.size() == 0) begin
            $display("%0t: response with nothing pending: target=%0d addr=%h irq=%b",
                     $time, got.target, got.mapped_address, got.irq);
            mismatches++;
            return;
         end
         want = pending_translations.pop_front();
         if (got.target !== want.target) begin
            $display("%0t: target expected %0d actual %0d", $time, want.target, got.target);
            mismatches++;
         end
         if (got.mapped_address !== want.mapped_address) begin
            $display("%0t: mapped_address expected %h actual %h",
                     $time, want.mapped_address, got.mapped_address);
            mismatches++;
         end
         if (got.irq !== want.irq) begin
            $display("%0t: irq expected %b actual %b", $time, want.irq, got.irq);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   bit                    calm = 1'b0;
   int                    stall_cycles = 0;
   mapper_model           book = new();

   cbm_req_if req_bus();
   cbm_rsp_if rsp_bus();

   cartridge_bank_mapper_irq dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_CPU_READ;
      req_bus.address = '0;
      req_bus.data    = '0;
      req_bus.cycles  = '0;
      rsp_bus.ready   = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready = !reset && (calm || $urandom_range(99) >= 21);
   end

   // Record every transfer on both channels and track how long nothing moves.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            book.note_event(req_type'{op_type'(req_bus.op), req_bus.address,
                                      req_bus.data, req_bus.cycles});
         if (rsp_bus.valid && rsp_bus.ready)
            book.check_translation(rsp_type'{target_type'(rsp_bus.target),
                                             rsp_bus.mapped_address, rsp_bus.irq});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_event(op_type o, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d,
                             logic [BYTE_W-1:0] c);
      while (!calm && $urandom_range(99) < 21) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.op      = o;
      req_bus.address = a;
      req_bus.data    = d;
      req_bus.cycles  = c;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_random_event();
      int                pick;
      int                shade;
      op_type            o;
      logic [ADDR_W-1:0] a;
      logic [BYTE_W-1:0] d;
      logic [BYTE_W-1:0] c;
      pick  = $urandom_range(99);
      shade = $urandom_range(99);
      a     = ADDR_W'($urandom);
      d     = BYTE_W'($urandom);
      c     = BYTE_W'($urandom);
      if (pick < 30) begin
         o = OP_CPU_WRITE;
         // mostly bank loads, seldom a clear so the interrupt gets a chance to fire
         if (shade < 70) a = {12'h800, 4'($urandom_range(11))};
         else if (shade < 75) a = {12'h800, 4'($urandom_range(15, 12))};
         else if (shade < 85) a = {3'b011, 13'($urandom)};
      end else if (pick < 55) begin
         o = OP_CPU_READ;
         if (shade < 60) a[15] = 1'b1;
         else if (shade < 80) a = {3'b011, 13'($urandom)};
      end else if (pick < 78) begin
         o = OP_PPU_READ;
         if (shade < 10) a[13:8] = 6'h3F;
      end else begin
         o = OP_TICK;
         if (shade < 50) c[7] = 1'b1;
      end
      send_event(o, a, d, c);
   endtask

   // Write one mask, then read it back; called at a falling edge.
   task automatic csr_write(reg_index_type idx, logic [BYTE_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.set_mask(idx, value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $display("%0t: mask %0d readback expected %h actual %h",
                  $time, idx, CSR_DATA_W'(value), csr_prdata);
         book.mismatches++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (book.pending_translations.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [BYTE_W-1:0] prg_masks [PHASES];
      logic [BYTE_W-1:0] chr_masks [PHASES];
      prg_masks = '{8'hFF, 8'h00, 8'h0F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
      chr_masks = '{8'hFF, 8'h00, 8'h1F, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
      prg_masks[5] = BYTE_W'($urandom);
      chr_masks[5] = BYTE_W'($urandom);
      prg_masks[6] = BYTE_W'($urandom);
      chr_masks[6] = BYTE_W'($urandom);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         csr_write(REG_PRG_MASK, prg_masks[ph]);
         csr_write(REG_CHR_MASK, chr_masks[ph]);
         calm = (ph == CALM_PHASE);
         if (ph == 0) begin
            send_event(OP_CPU_WRITE, 16'h8000, 8'hFF, 8'h00);
            send_event(OP_CPU_WRITE, 16'h8007, 8'h81, 8'hFF);
            send_event(OP_CPU_WRITE, 16'h8008, 8'h00, 8'h00);
            send_event(OP_CPU_WRITE, 16'h800B, 8'hFF, 8'h00);
            send_event(OP_CPU_WRITE, 16'h800C, 8'h55, 8'h00);
            send_event(OP_CPU_WRITE, 16'h800D, 8'h00, 8'h00);
            send_event(OP_CPU_WRITE, 16'h800E, 8'hAA, 8'h00);
            send_event(OP_CPU_WRITE, 16'h800F, 8'h00, 8'h00);
            send_event(OP_CPU_WRITE, 16'h8010, 8'h12, 8'h00);
            send_event(OP_CPU_WRITE, 16'hFFFF, 8'h34, 8'h00);
            send_event(OP_CPU_WRITE, 16'h6000, 8'h00, 8'h00);
            send_event(OP_CPU_WRITE, 16'h5FFF, 8'h00, 8'h00);
            send_event(OP_CPU_READ,  16'h0000, 8'h00, 8'h00);
            send_event(OP_CPU_READ,  16'h6000, 8'h00, 8'h00);
            send_event(OP_CPU_READ,  16'h7FFF, 8'h00, 8'h00);
            send_event(OP_CPU_READ,  16'h8000, 8'h00, 8'h00);
            send_event(OP_CPU_READ,  16'hFFFF, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'h0000, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'h1FFF, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'h2000, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'h3EFF, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'h3F00, 8'h00, 8'h00);
            send_event(OP_PPU_READ,  16'hFFFF, 8'h00, 8'h00);
            send_event(OP_TICK,      16'h0000, 8'h00, 8'h00);
            send_event(OP_TICK,      16'hFFFF, 8'hFF, 8'hFF);
         end
         repeat (RANDOM_EVENTS) send_random_event();
         drain();
      end

      repeat (8) @(posedge clock);
      if (book.mismatches == 0 && book.pending_translations.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
